>>> design/first_fit_block_run_allocator_defines.svh
// ----------------------------------------------------------------------------
// First-fit block run allocator: assertion macros
// Shared shorthand for the concurrent checks on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_RUN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBRA_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBRA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ffbra_pkg.sv
// ----------------------------------------------------------------------------
// ffbra_pkg
// Types, widths and codes shared by the first-fit block run allocator.
// ----------------------------------------------------------------------------
package ffbra_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 64;

    localparam int OPCODE_W     = 1;
    localparam int UNIT_W       = 19;
    localparam int STATUS_W     = 2;
    localparam int BLOCK_SIZE_W = 13;
    localparam int BASE_W       = 16;
    localparam int POOL_W       = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIVIDEND_W   = UNIT_W + 1;

    localparam int BLOCK_SIZE_MAX = 4096;
    // Reserved blocks sit on a stride of four, so two index bits decide.
    localparam int RESERVE_LOG2   = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_UNAVAIL     = 2'd1,
        ST_OUT_OF_POOL = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCK_SIZE    = 2'd0,
        CFG_BASE_UNIT_ID  = 2'd1,
        CFG_BLOCKS_IN_USE = 2'd2,
        CFG_RESERVE       = 2'd3
    } cfg_index_t;

    // Which quotient a division produces: blocks needed, release start block,
    // release block count.
    typedef enum logic [1:0] {
        DIV_NEED = 2'd0,
        DIV_SBLK = 2'd1,
        DIV_NBLK = 2'd2
    } div_src_t;

    typedef struct packed {
        logic      load_item;
        logic      div_start;
        div_src_t  div_src;
        logic      div_capture;
        div_src_t  div_dst;
        logic      scan_init;
        logic      scan_step;
        logic      calc;
        logic      mark_init_rel;
        logic      mark_step;
        logic      set_status;
        status_t   status_code;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic op_release;
        logic count_zero;
        logic below_base;
        logic div_done;
        logic range_bad;
        logic nblk_zero;
        logic scan_end;
        logic scan_hit;
        logic mark_last;
        logic out_free;
    } stat_t;

endpackage

>>> design/ffbra_req_if.sv
// ----------------------------------------------------------------------------
// ffbra_req_if
// Request channel: allocate or release transactions with valid/ready.
// ----------------------------------------------------------------------------
interface ffbra_req_if;
    logic                           valid;
    logic                           ready;
    logic [ffbra_pkg::OPCODE_W-1:0] opcode;
    logic [ffbra_pkg::UNIT_W-1:0]   unit_count;
    logic [ffbra_pkg::UNIT_W-1:0]   first_unit;

    modport source (output valid, output opcode, output unit_count, output first_unit,
                    input ready);
    modport sink   (input valid, input opcode, input unit_count, input first_unit,
                    output ready);
endinterface

>>> design/ffbra_rsp_if.sv
// ----------------------------------------------------------------------------
// ffbra_rsp_if
// Response channel: one result transaction per request, valid/ready.
// ----------------------------------------------------------------------------
interface ffbra_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ffbra_pkg::STATUS_W-1:0] status;
    logic [ffbra_pkg::UNIT_W-1:0]   start_unit;
    logic [ffbra_pkg::UNIT_W-1:0]   granted_units;

    modport source (output valid, output status, output start_unit, output granted_units,
                    input ready);
    modport sink   (input valid, input status, input start_unit, input granted_units,
                    output ready);
endinterface

>>> design/first_fit_block_run_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_run_allocator
// First-fit allocator of contiguous block runs over a busy map.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  req      in         opcode, unit_count, first_unit
//  rsp      out        status, start_unit, granted_units
//  cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
//  One request is in work at a time; all divisions use the shared divider.
//  Allocate: one division, a scan of S blocks (at most the pool size), then
//  N blocks marked. Release: two divisions, a range check, N blocks freed.
//  A zero-unit allocate or a release below the base goes straight to reply.
//  Reset clears the busy map at once; no clearing pass is needed.
//  A pending response waits in its own register, so the next request is
//  taken while rsp is stalled.
// ----------------------------------------------------------------------------
module first_fit_block_run_allocator #(
    parameter int MAX_BLOCKS = ffbra_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ffbra_req_if.sink                         req,
    ffbra_rsp_if.source                       rsp,
    input  logic                              cfg_we,
    input  logic [ffbra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ffbra_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ffbra_pkg::cmd_t  cmd;
    ffbra_pkg::stat_t st;

    ffbra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    ffbra_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (req.opcode),
        .unit_count    (req.unit_count),
        .first_unit    (req.first_unit),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .status        (rsp.status),
        .start_unit    (rsp.start_unit),
        .granted_units (rsp.granted_units),
        .cmd           (cmd),
        .st            (st)
    );

endmodule

>>> design/ffbra_div.sv
// ----------------------------------------------------------------------------
// ffbra_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module ffbra_div #(
    parameter int DIVIDEND_W = ffbra_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = ffbra_pkg::BLOCK_SIZE_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;

    // The remainder stays below the divisor, so its top bit is always zero.
    assign rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_shift - {1'b0, dsr_reg};
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/ffbra_ctrl.sv
// ----------------------------------------------------------------------------
// ffbra_ctrl
// Sequencer: steps each transaction through divide, scan (allocate only), mark and reply.
// ----------------------------------------------------------------------------
module ffbra_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ffbra_pkg::stat_t st,
    output ffbra_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_DIV_A = 9'b000000100,
        S_DIV_B = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_SCAN  = 9'b000100000,
        S_CALC  = 9'b001000000,
        S_MARK  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (!st.op_release)
                begin
                    if (st.count_zero)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_src   = ffbra_pkg::DIV_NEED;
                        cmd.scan_init = 1'b1;
                        state_next    = S_DIV_A;
                    end
                end
                else if (st.below_base)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffbra_pkg::ST_OUT_OF_POOL;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = ffbra_pkg::DIV_SBLK;
                    state_next    = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                if (st.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    if (!st.op_release)
                    begin
                        cmd.div_dst = ffbra_pkg::DIV_NEED;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        // The count division starts as the start-block quotient lands.
                        cmd.div_dst   = ffbra_pkg::DIV_SBLK;
                        cmd.div_start = 1'b1;
                        cmd.div_src   = ffbra_pkg::DIV_NBLK;
                        state_next    = S_DIV_B;
                    end
                end
            end
            S_DIV_B:
            begin
                if (st.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    cmd.div_dst     = ffbra_pkg::DIV_NBLK;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.range_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffbra_pkg::ST_OUT_OF_POOL;
                    state_next      = S_OUT;
                end
                else if (st.nblk_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mark_init_rel = 1'b1;
                    state_next        = S_MARK;
                end
            end
            S_SCAN:
            begin
                if (st.scan_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffbra_pkg::ST_UNAVAIL;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (st.scan_hit)
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_MARK;
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (st.mark_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ffbra_datapath.sv
// ----------------------------------------------------------------------------
// ffbra_datapath
// Configuration, busy map, divider, run scanner and the result register.
// ----------------------------------------------------------------------------
module ffbra_datapath #(
    parameter int MAX_BLOCKS = ffbra_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ffbra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ffbra_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [ffbra_pkg::OPCODE_W-1:0]    opcode,
    input  logic [ffbra_pkg::UNIT_W-1:0]      unit_count,
    input  logic [ffbra_pkg::UNIT_W-1:0]      first_unit,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [ffbra_pkg::STATUS_W-1:0]    status,
    output logic [ffbra_pkg::UNIT_W-1:0]      start_unit,
    output logic [ffbra_pkg::UNIT_W-1:0]      granted_units,
    input  ffbra_pkg::cmd_t                   cmd,
    output ffbra_pkg::stat_t                  st
);

    localparam int UNIT_W = ffbra_pkg::UNIT_W;
    localparam int BS_W   = ffbra_pkg::BLOCK_SIZE_W;
    localparam int BASE_W = ffbra_pkg::BASE_W;
    localparam int POOL_W = ffbra_pkg::POOL_W;
    localparam int DIV_W  = ffbra_pkg::DIVIDEND_W;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PROD_W = CNT_W + BS_W;
    localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
    localparam int RSV_W  = ffbra_pkg::RESERVE_LOG2;

    // Configuration registers.
    logic [BS_W-1:0]   block_size_reg;
    logic [BASE_W-1:0] base_reg;
    logic [POOL_W-1:0] blocks_in_use_reg;
    logic              reserve_reg;

    // Transaction and working registers.
    ffbra_pkg::opcode_t op_reg;
    logic [UNIT_W-1:0]  count_reg;
    logic [UNIT_W-1:0]  first_reg;
    logic [DIV_W-1:0]   need_reg;
    logic [DIV_W-1:0]   sblk_reg;
    logic [DIV_W-1:0]   nblk_reg;
    logic [CNT_W-1:0]   scan_k_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [CNT_W-1:0]   run_start_reg;
    logic [CNT_W-1:0]   mark_k_reg;
    logic [CNT_W-1:0]   mark_end_reg;
    ffbra_pkg::status_t status_reg;
    logic [UNIT_W-1:0]  start_reg;
    logic [UNIT_W-1:0]  granted_reg;
    logic [MAX_BLOCKS-1:0] busy_reg;

    // Result register.
    logic               out_valid_reg;
    ffbra_pkg::status_t out_status_reg;
    logic [UNIT_W-1:0]  out_start_reg;
    logic [UNIT_W-1:0]  out_granted_reg;

    logic [BS_W-1:0]        eff_bs;
    logic [CNT_W-1:0]       pool;
    logic [DIV_W-1:0]       dividend;
    logic                   div_done;
    logic [DIV_W-1:0]       quotient;
    logic [CNT_W+RSV_W-1:0] scan_ext;
    logic                   blk_busy;
    logic                   scan_end;
    logic                   scan_hit;
    logic [CNT_W-1:0]       hit_start;
    logic [PROD_W-1:0]      prod_start;
    logic [PROD_W-1:0]      prod_granted;
    logic [SUM_W-1:0]       start_sum;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg    <= BS_W'(1);
            base_reg          <= '0;
            blocks_in_use_reg <= '0;
            reserve_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (ffbra_pkg::cfg_index_t'(cfg_index))
                ffbra_pkg::CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data[BS_W-1:0];
                ffbra_pkg::CFG_BASE_UNIT_ID:  base_reg          <= cfg_data[BASE_W-1:0];
                ffbra_pkg::CFG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[POOL_W-1:0];
                ffbra_pkg::CFG_RESERVE:       reserve_reg       <= cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        if (block_size_reg == '0)
        begin
            eff_bs = BS_W'(1);
        end
        else if (block_size_reg > BS_W'(ffbra_pkg::BLOCK_SIZE_MAX))
        begin
            eff_bs = BS_W'(ffbra_pkg::BLOCK_SIZE_MAX);
        end
        else
        begin
            eff_bs = block_size_reg;
        end
    end

    always_comb
    begin
        if (32'(blocks_in_use_reg) > 32'(MAX_BLOCKS))
        begin
            pool = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            pool = CNT_W'(blocks_in_use_reg);
        end
    end

    // ---------------- division ----------------
    always_comb
    begin
        case (cmd.div_src)
            ffbra_pkg::DIV_NEED: dividend = DIV_W'(count_reg) + DIV_W'(eff_bs) - DIV_W'(1);
            ffbra_pkg::DIV_SBLK: dividend = DIV_W'(first_reg - UNIT_W'(base_reg));
            default:             dividend = DIV_W'(count_reg);
        endcase
    end

    ffbra_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (BS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (eff_bs),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- run scan ----------------
    assign scan_ext = {{RSV_W{1'b0}}, scan_k_reg};
    assign scan_end = scan_k_reg >= pool;
    assign blk_busy = busy_reg[scan_k_reg[IDX_W-1:0]]
                   || (reserve_reg && (scan_ext[RSV_W-1:0] == '0));
    assign scan_hit = !scan_end && !blk_busy && ((DIV_W'(run_reg) + DIV_W'(1)) >= need_reg);
    assign hit_start = (run_reg == '0) ? scan_k_reg : run_start_reg;

    // The hit guarantees the block count is no larger than the pool.
    assign prod_start   = PROD_W'(run_start_reg) * PROD_W'(eff_bs);
    assign prod_granted = PROD_W'(need_reg[CNT_W-1:0]) * PROD_W'(eff_bs);
    assign start_sum    = SUM_W'(prod_start) + SUM_W'(base_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= ffbra_pkg::opcode_t'(opcode);
            count_reg <= unit_count;
            first_reg <= first_unit;
        end

        if (cmd.div_capture)
        begin
            case (cmd.div_dst)
                ffbra_pkg::DIV_NEED: need_reg <= quotient;
                ffbra_pkg::DIV_SBLK: sblk_reg <= quotient;
                default:             nblk_reg <= quotient;
            endcase
        end

        if (cmd.scan_init)
        begin
            scan_k_reg <= '0;
            run_reg    <= '0;
        end
        else if (cmd.scan_step && !scan_end)
        begin
            scan_k_reg <= scan_k_reg + 1'b1;
            if (blk_busy)
            begin
                run_reg <= '0;
            end
            else
            begin
                run_reg       <= run_reg + 1'b1;
                run_start_reg <= hit_start;
            end
        end

        if (cmd.scan_step && scan_hit)
        begin
            mark_k_reg   <= hit_start;
            mark_end_reg <= scan_k_reg;
        end
        else if (cmd.mark_init_rel)
        begin
            mark_k_reg   <= CNT_W'(sblk_reg);
            mark_end_reg <= CNT_W'(sblk_reg + nblk_reg - DIV_W'(1));
        end
        else if (cmd.mark_step)
        begin
            mark_k_reg <= mark_k_reg + 1'b1;
        end

        if (cmd.load_item)
        begin
            status_reg  <= ffbra_pkg::ST_OK;
            start_reg   <= '0;
            granted_reg <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.calc)
            begin
                start_reg   <= UNIT_W'(start_sum);
                granted_reg <= UNIT_W'(prod_granted);
            end
        end
    end

    // ---------------- busy map ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (cmd.mark_step)
        begin
            busy_reg[mark_k_reg[IDX_W-1:0]] <= (op_reg == ffbra_pkg::OP_ALLOC);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg  <= status_reg;
            out_start_reg   <= start_reg;
            out_granted_reg <= granted_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign start_unit    = out_start_reg;
    assign granted_units = out_granted_reg;

    // ---------------- status to the sequencer ----------------
    always_comb
    begin
        st            = '0;
        st.op_release = (op_reg == ffbra_pkg::OP_RELEASE);
        st.count_zero = (count_reg == '0);
        st.below_base = (first_reg < UNIT_W'(base_reg));
        st.div_done   = div_done;
        st.range_bad  = (sblk_reg > DIV_W'(pool)) || (nblk_reg > (DIV_W'(pool) - sblk_reg));
        st.nblk_zero  = (nblk_reg == '0);
        st.scan_end   = scan_end;
        st.scan_hit   = scan_hit;
        st.mark_last  = (mark_k_reg == mark_end_reg);
        st.out_free   = !out_valid_reg || out_ready;
    end

endmodule

>>> design/ffbra_checker.sv
// ----------------------------------------------------------------------------
// ffbra_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "first_fit_block_run_allocator_defines.svh"

module ffbra_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [ffbra_pkg::STATUS_W-1:0] status,
    input logic [ffbra_pkg::UNIT_W-1:0]   start_unit,
    input logic [ffbra_pkg::UNIT_W-1:0]   granted_units
);

    logic [1:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Requests taken whose responses have not been delivered yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    `FFBRA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid, "response dropped while stalled")
    `FFBRA_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_acc, !in_ready, "request taken while another is in work")
    `FFBRA_ASSERT_SAME(a_no_orphan, clk, rst_n, out_valid, pending_reg != 2'd0, "response without a request")
    `FFBRA_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, status != 2'd3, "undefined status code")
    `FFBRA_ASSERT_SAME(a_fail_empty, clk, rst_n, out_valid && (status != ffbra_pkg::ST_OK), (start_unit == '0) && (granted_units == '0), "failed request reports a grant")

endmodule

bind first_fit_block_run_allocator ffbra_checker u_ffbra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .start_unit    (rsp.start_unit),
    .granted_units (rsp.granted_units)
);
